FILE: rtl/tlfo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tlfo_pkg;

   localparam int SAMPLE_W = 16;
   localparam int CFG_W    = 31;
   localparam int MAG_W    = SAMPLE_W + 1;
   localparam int PROD_W   = MAG_W + CFG_W;
   localparam int QUO_W    = SAMPLE_W;
   localparam int STEP_W   = $clog2(QUO_W);

   localparam logic [CFG_W-1:0] POS_MAX    = {CFG_W{1'b1}};
   localparam logic [CFG_W-1:0] PLAY_RESET = CFG_W'(7497000);
   localparam logic [CFG_W-1:0] FADE_RESET = CFG_W'(441000);

   localparam logic CSR_PLAY_FRAMES = 1'b0;
   localparam logic CSR_FADE_FRAMES = 1'b1;

   localparam logic OP_AUDIO  = 1'b0;
   localparam logic OP_REWIND = 1'b1;

   typedef enum logic [1:0] {
      T_IDLE,
      T_BUSY,
      T_HOLD
   } top_state_type;

   typedef enum logic [1:0] {
      L_IDLE,
      L_MUL,
      L_LOAD,
      L_DIV
   } lane_state_type;

   typedef struct packed {
      logic             start;
      logic [CFG_W-1:0] gain;
      logic [CFG_W-1:0] divisor;
   } lane_req_type;

endpackage

`default_nettype wire

FILE: rtl/tlfo_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module tlfo_lane import tlfo_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire lane_req_type               lane_req,
   input  wire logic signed [SAMPLE_W-1:0] sample,
   output logic                            lane_done,
   output logic signed [SAMPLE_W-1:0]      lane_result
);

   lane_state_type state_ff, state_in;

   logic                neg_ff;
   logic [MAG_W-1:0]    mag_ff;
   logic [CFG_W-1:0]    gain_ff;
   logic [CFG_W-1:0]    div_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [CFG_W-1:0]    rem_ff;
   logic [QUO_W-1:0]    quo_ff;
   logic [STEP_W-1:0]   step_ff;

   logic                capture;
   logic                do_mul;
   logic                do_load;
   logic                do_step;

   logic [MAG_W-1:0]    mag_in;
   logic [PROD_W-1:0]   prod_in;
   logic [CFG_W:0]      trial;
   logic [CFG_W:0]      div_ext;
   logic                fits;
   logic [CFG_W:0]      rem_next;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         L_IDLE: begin
            if (lane_req.start) begin
               state_in = L_MUL;
            end
         end
         L_MUL:  state_in = L_LOAD;
         L_LOAD: state_in = L_DIV;
         L_DIV: begin
            if (step_ff == STEP_W'(QUO_W - 1)) begin
               state_in = L_IDLE;
            end
         end
         default: state_in = L_IDLE;
      endcase
   end

   always_comb begin
      capture   = (state_ff == L_IDLE) && lane_req.start;
      do_mul    = (state_ff == L_MUL);
      do_load   = (state_ff == L_LOAD);
      do_step   = (state_ff == L_DIV);
      lane_done = (state_ff == L_DIV) && (step_ff == STEP_W'(QUO_W - 1));
   end

   // sign and magnitude of the sample, magnitude up to 2^15
   assign mag_in  = sample[SAMPLE_W-1] ? (MAG_W'(1) << SAMPLE_W) - MAG_W'({1'b0, sample})
                                       : MAG_W'({1'b0, sample});
   assign prod_in = PROD_W'(mag_ff) * PROD_W'(gain_ff);

   // restoring step: remainder stays below the divisor
   assign trial    = {rem_ff, quo_ff[QUO_W-1]};
   assign div_ext  = {1'b0, div_ff};
   assign fits     = (trial >= div_ext);
   assign rem_next = fits ? (trial - div_ext) : trial;

   assign lane_result = neg_ff ? SAMPLE_W'(SAMPLE_W'(0) - quo_ff) : SAMPLE_W'(quo_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         neg_ff  <= sample[SAMPLE_W-1];
         mag_ff  <= mag_in;
         gain_ff <= lane_req.gain;
         div_ff  <= lane_req.divisor;
      end
      if (do_mul) begin
         prod_ff <= prod_in;
      end
      if (do_load) begin
         rem_ff  <= prod_ff[PROD_W-2:QUO_W];
         quo_ff  <= prod_ff[QUO_W-1:0];
         step_ff <= '0;
      end
      if (do_step) begin
         rem_ff  <= rem_next[CFG_W-1:0];
         quo_ff  <= {quo_ff[QUO_W-2:0], fits};
         step_ff <= step_ff + STEP_W'(1);
      end
   end

endmodule

`default_nettype wire

FILE: rtl/track_length_linear_fade_out_core.sv
// An audio frame that gives a result goes through a multiply and a 16-step serial divider in
// each lane; req_stall holds off new items until its result is in the output register.
// Rewind items and frames past the track end give no result and leave the lanes idle.
// Reset: synchronous, active high; clears the frame count, loads the default play and
// fade lengths and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module track_length_linear_fade_out_core import tlfo_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic                       req_opcode,
   input  wire logic signed [SAMPLE_W-1:0] req_left_in,
   input  wire logic signed [SAMPLE_W-1:0] req_right_in,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0]      rsp_left_out,
   output logic signed [SAMPLE_W-1:0]      rsp_right_out,
   output logic                            rsp_last_frame,
   input  wire logic                       csr_write_enable,
   input  wire logic                       csr_index,
   input  wire logic [CFG_W-1:0]           csr_write_data
);

   top_state_type state_ff, state_in;

   logic [CFG_W-1:0]           play_ff;
   logic [CFG_W-1:0]           fade_ff;
   logic [CFG_W-1:0]           pos_ff;
   logic                       last_ff;
   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_left_ff;
   logic signed [SAMPLE_W-1:0] rsp_right_ff;
   logic                       rsp_last_ff;

   logic                       accept;
   logic                       out_free;
   logic                       load_rsp;
   logic                       is_rewind;
   logic                       in_track;
   logic                       in_fade;
   logic                       start;

   logic [CFG_W:0]             total;
   logic [CFG_W:0]             pos_ext;
   logic [CFG_W:0]             gain_full;
   lane_req_type               lane_req;

   logic                       left_done;
   logic                       right_done;
   logic                       lanes_done;
   logic signed [SAMPLE_W-1:0] left_result;
   logic signed [SAMPLE_W-1:0] right_result;

   assign total     = {1'b0, play_ff} + {1'b0, fade_ff};
   assign pos_ext   = {1'b0, pos_ff};
   assign gain_full = total - pos_ext;
   assign is_rewind = (req_opcode == OP_REWIND);
   assign in_track  = (pos_ext < total);
   assign in_fade   = (pos_ext >= {1'b0, play_ff});
   assign start     = accept && !is_rewind && in_track;

   // full level runs through the lanes at unit gain over unit divisor
   assign lane_req.start   = start;
   assign lane_req.gain    = in_fade ? gain_full[CFG_W-1:0] : CFG_W'(1);
   assign lane_req.divisor = in_fade ? fade_ff : CFG_W'(1);

   assign lanes_done = left_done && right_done;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         T_IDLE: begin
            if (start) begin
               state_in = T_BUSY;
            end
         end
         T_BUSY: begin
            if (lanes_done) begin
               state_in = T_HOLD;
            end
         end
         T_HOLD: begin
            if (out_free) begin
               state_in = T_IDLE;
            end
         end
         default: state_in = T_IDLE;
      endcase
   end

   always_comb begin
      req_stall = (state_ff != T_IDLE);
      accept    = req_valid && !req_stall;
      out_free  = !rsp_valid_ff || !rsp_stall;
      load_rsp  = (state_ff == T_HOLD) && out_free;
   end

   tlfo_lane u_lane_left (
      .clock       (clock),
      .reset       (reset),
      .lane_req    (lane_req),
      .sample      (req_left_in),
      .lane_done   (left_done),
      .lane_result (left_result)
   );

   tlfo_lane u_lane_right (
      .clock       (clock),
      .reset       (reset),
      .lane_req    (lane_req),
      .sample      (req_right_in),
      .lane_done   (right_done),
      .lane_result (right_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         play_ff      <= PLAY_RESET;
         fade_ff      <= FADE_RESET;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_PLAY_FRAMES: play_ff <= csr_write_data;
               CSR_FADE_FRAMES: fade_ff <= csr_write_data;
               default:         play_ff <= play_ff;
            endcase
         end
         if (accept && is_rewind) begin
            pos_ff <= '0;
         end else if (start && (pos_ff != POS_MAX)) begin
            pos_ff <= pos_ff + CFG_W'(1);
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         last_ff <= ((pos_ext + (CFG_W+1)'(1)) == total);
      end
      if (load_rsp) begin
         rsp_left_ff  <= left_result;
         rsp_right_ff <= right_result;
         rsp_last_ff  <= last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_left_out   = rsp_left_ff;
   assign rsp_right_out  = rsp_right_ff;
   assign rsp_last_frame = rsp_last_ff;

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import tlfo_pkg::*;

   localparam int ITEM_GOAL   = 1450;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE      = 30;
   localparam int HOLD_CYCLES = 400;
   localparam int REPORT_MAX  = 10;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
      logic                       last;
   } frame_out_type;

   typedef struct {
      bit                         is_write;
      logic                       idx;
      logic [CFG_W-1:0]           value;
      logic                       op;
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
      bit                         known;
      bit                         gives;
      frame_out_type              want;
   } script_row_type;

   logic                       clock;
   logic                       reset            = 1'b1;
   logic                       req_valid        = 1'b0;
   logic                       req_stall;
   logic                       req_opcode       = OP_AUDIO;
   logic signed [SAMPLE_W-1:0] req_left_in      = '0;
   logic signed [SAMPLE_W-1:0] req_right_in     = '0;
   logic                       rsp_valid;
   logic                       rsp_stall        = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_left_out;
   logic signed [SAMPLE_W-1:0] rsp_right_out;
   logic                       rsp_last_frame;
   logic                       csr_write_enable = 1'b0;
   logic                       csr_index        = CSR_PLAY_FRAMES;
   logic [CFG_W-1:0]           csr_write_data   = '0;

   track_length_linear_fade_out_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_left_in      (req_left_in),
      .req_right_in     (req_right_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_left_out     (rsp_left_out),
      .rsp_right_out    (rsp_right_out),
      .rsp_last_frame   (rsp_last_frame),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // track state mirrored from the block
   logic [CFG_W-1:0] play_len  = PLAY_RESET;
   logic [CFG_W-1:0] fade_len  = FADE_RESET;
   logic [CFG_W-1:0] frame_pos = '0;

   frame_out_type  pending_frames[$];
   script_row_type script[$];

   bit calm        = 1'b0;
   bit squeeze_req = 1'b0;
   bit squeeze_done = 1'b0;
   int hold_left   = 0;

   int cycles       = 0;
   int err_count    = 0;
   int item_total   = 0;
   int frames_seen  = 0;
   int faded_count  = 0;
   int ends_count   = 0;
   int rewind_count = 0;
   int drop_count   = 0;
   int write_count  = 0;

   frame_out_type got_frame;
   frame_out_type want_frame;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic signed [SAMPLE_W-1:0] scale_sample(
      input logic [SAMPLE_W-1:0] s, input logic [63:0] gain, input logic [63:0] div);
      logic [63:0] mag;
      logic [63:0] q;
      mag = s[SAMPLE_W-1] ? 64'h10000 - {48'b0, s} : {48'b0, s};
      q   = (mag * gain) / div;
      return s[SAMPLE_W-1] ? SAMPLE_W'(64'h10000 - q) : q[SAMPLE_W-1:0];
   endfunction

   function automatic bit advance_track(input logic op,
      input logic signed [SAMPLE_W-1:0] left, input logic signed [SAMPLE_W-1:0] right,
      output frame_out_type made);
      logic [63:0] total;
      logic [63:0] gain;
      made  = '0;
      total = {33'b0, play_len} + {33'b0, fade_len};
      if (op == OP_REWIND) begin
         frame_pos = '0;
         return 1'b0;
      end
      if ({33'b0, frame_pos} >= total)
         return 1'b0;
      made.left  = left;
      made.right = right;
      if (frame_pos >= play_len) begin
         gain       = total - {33'b0, frame_pos};
         made.left  = scale_sample(left, gain, {33'b0, fade_len});
         made.right = scale_sample(right, gain, {33'b0, fade_len});
         faded_count++;
      end
      made.last = ({33'b0, frame_pos} + 64'd1 == total);
      if (made.last)
         ends_count++;
      if (frame_pos != POS_MAX)
         frame_pos = frame_pos + 1'b1;
      return 1'b1;
   endfunction

   function automatic logic [CFG_W-1:0] pick_len();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return POS_MAX;
         2:       return CFG_W'($urandom);
         default: return CFG_W'($urandom_range(1, 24));
      endcase
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0:       return 16'sh8000;
         1:       return 16'sh7FFF;
         2:       return 16'sh0000;
         3:       return -16'sd1;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic void add_write(input logic idx, input logic [CFG_W-1:0] value);
      script_row_type row;
      row          = '{default: '0};
      row.is_write = 1'b1;
      row.idx      = idx;
      row.value    = value;
      script.push_back(row);
   endfunction

   function automatic void add_frame(input logic op,
      input logic signed [SAMPLE_W-1:0] left, input logic signed [SAMPLE_W-1:0] right);
      script_row_type row;
      row       = '{default: '0};
      row.op    = op;
      row.left  = left;
      row.right = right;
      script.push_back(row);
   endfunction

   function automatic void add_known(input logic op,
      input logic signed [SAMPLE_W-1:0] left, input logic signed [SAMPLE_W-1:0] right,
      input bit gives, input logic signed [SAMPLE_W-1:0] want_left,
      input logic signed [SAMPLE_W-1:0] want_right, input logic want_last);
      script_row_type row;
      row       = '{default: '0};
      row.op    = op;
      row.left  = left;
      row.right = right;
      row.known = 1'b1;
      row.gives = gives;
      row.want  = '{want_left, want_right, want_last};
      script.push_back(row);
   endfunction

   task automatic send_item(input logic op,
      input logic signed [SAMPLE_W-1:0] left, input logic signed [SAMPLE_W-1:0] right,
      input bit known, input bit gives, input frame_out_type want);
      frame_out_type made;
      bit            produced;
      @(negedge clock);
      while (!calm && $urandom_range(0, 99) < 20) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_opcode   <= op;
      req_left_in  <= left;
      req_right_in <= right;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      produced = advance_track(op, left, right, made);
      if (known) begin
         produced = gives;
         made     = want;
      end
      if (produced)
         pending_frames.push_back(made);
      if (op == OP_REWIND)
         rewind_count++;
      else if (!produced)
         drop_count++;
      item_total++;
   endtask

   task automatic settle_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_frames.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_PLAY_FRAMES)
         play_len = value;
      else
         fade_len = value;
      write_count++;
   endtask

   task automatic note_mismatch(input string what, input frame_out_type want,
      input frame_out_type got);
      err_count++;
      if (err_count <= REPORT_MAX)
         $display("%s: expected L=%0d R=%0d last=%0b, got L=%0d R=%0d last=%0b", what,
                  want.left, want.right, want.last, got.left, got.right, got.last);
   endtask

   always @(negedge clock) begin
      if (squeeze_req && !squeeze_done) begin
         hold_left    = HOLD_CYCLES;
         squeeze_done = 1'b1;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= !calm && ($urandom_range(0, 99) < 20);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got_frame = '{rsp_left_out, rsp_right_out, rsp_last_frame};
         if (pending_frames.size() == 0) begin
            note_mismatch("result with nothing pending", '0, got_frame);
         end else begin
            want_frame = pending_frames.pop_front();
            frames_seen++;
            if (got_frame !== want_frame)
               note_mismatch("frame mismatch", want_frame, got_frame);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still pending", cycles,
                  pending_frames.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      logic op;
      bit   at_end;
      int   frames;

      add_known(OP_AUDIO, 16'sh7FFF, 16'sh8000, 1, 16'sh7FFF, 16'sh8000, 1'b0);
      add_known(OP_AUDIO, 16'sh0000, -16'sd1, 1, 16'sh0000, -16'sd1, 1'b0);
      add_known(OP_REWIND, 16'sh1234, -16'sd4660, 0, '0, '0, 1'b0);
      add_write(CSR_PLAY_FRAMES, 31'd2);
      add_write(CSR_FADE_FRAMES, 31'd3);
      add_known(OP_AUDIO, 16'sh8000, 16'sh7FFF, 1, 16'sh8000, 16'sh7FFF, 1'b0);
      add_known(OP_AUDIO, 16'sd1000, -16'sd1000, 1, 16'sd1000, -16'sd1000, 1'b0);
      add_frame(OP_AUDIO, 16'sd30000, -16'sd30000);
      add_frame(OP_AUDIO, 16'sh8000, 16'sh7FFF);
      add_frame(OP_AUDIO, -16'sd7, 16'sd7);
      add_known(OP_AUDIO, 16'sd5, 16'sd5, 0, '0, '0, 1'b0);
      add_known(OP_REWIND, 16'sh7FFF, 16'sh8000, 0, '0, '0, 1'b0);
      add_known(OP_AUDIO, 16'sd100, -16'sd100, 1, 16'sd100, -16'sd100, 1'b0);
      add_write(CSR_PLAY_FRAMES, 31'd0);
      add_write(CSR_FADE_FRAMES, 31'd0);
      add_known(OP_REWIND, 16'sh0000, 16'sh0000, 0, '0, '0, 1'b0);
      add_known(OP_AUDIO, 16'sh7FFF, 16'sh7FFF, 0, '0, '0, 1'b0);
      add_write(CSR_FADE_FRAMES, 31'd1);
      add_known(OP_REWIND, -16'sd1, -16'sd1, 0, '0, '0, 1'b0);
      add_known(OP_AUDIO, 16'sh8000, 16'sd1, 1, 16'sh8000, 16'sd1, 1'b1);
      add_known(OP_AUDIO, 16'sd9, 16'sd9, 0, '0, '0, 1'b0);
      add_write(CSR_FADE_FRAMES, POS_MAX);
      add_known(OP_REWIND, 16'sh0000, 16'sh0000, 0, '0, '0, 1'b0);
      add_known(OP_AUDIO, 16'sh8000, 16'sh7FFF, 1, 16'sh8000, 16'sh7FFF, 1'b0);
      add_frame(OP_AUDIO, 16'sh8000, 16'sh7FFF);
      add_write(CSR_PLAY_FRAMES, POS_MAX);
      add_known(OP_REWIND, 16'sh0000, 16'sh0000, 0, '0, '0, 1'b0);
      add_known(OP_AUDIO, -16'sd1, 16'sd1, 1, -16'sd1, 16'sd1, 1'b0);
      add_write(CSR_PLAY_FRAMES, 31'd3);
      add_write(CSR_FADE_FRAMES, 31'd0);
      add_known(OP_REWIND, 16'sh0000, 16'sh0000, 0, '0, '0, 1'b0);
      add_known(OP_AUDIO, 16'sd11, -16'sd11, 1, 16'sd11, -16'sd11, 1'b0);
      add_known(OP_AUDIO, 16'sh5555, 16'shAAAA, 1, 16'sh5555, 16'shAAAA, 1'b0);
      add_known(OP_AUDIO, 16'sh7FFF, 16'sh8000, 1, 16'sh7FFF, 16'sh8000, 1'b1);
      add_known(OP_AUDIO, 16'sd3, 16'sd3, 0, '0, '0, 1'b0);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].is_write) begin
            settle_block();
            write_reg(script[i].idx, script[i].value);
         end else begin
            send_item(script[i].op, script[i].left, script[i].right, script[i].known,
                      script[i].gives, script[i].want);
         end
      end

      while (item_total < ITEM_GOAL) begin
         settle_block();
         write_reg(CSR_PLAY_FRAMES, pick_len());
         write_reg(CSR_FADE_FRAMES, pick_len());
         if ($urandom_range(0, 3) != 0)
            send_item(OP_REWIND, pick_sample(), pick_sample(), 0, 0, '0);
         frames = $urandom_range(40, 120);
         repeat (frames) begin
            at_end = ({1'b0, frame_pos} >= {1'b0, play_len} + {1'b0, fade_len});
            calm   = (item_total >= 500 && item_total < 750);
            if (item_total >= 300)
               squeeze_req = 1'b1;
            op = ((at_end && $urandom_range(0, 3) != 0) || $urandom_range(0, 24) == 0)
                 ? OP_REWIND : OP_AUDIO;
            send_item(op, pick_sample(), pick_sample(), 0, 0, '0);
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_frames.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      $display("checked %0d output frames: %0d inside a fade, %0d marked as track end",
               frames_seen, faded_count, ends_count);
      $display("also sent %0d rewinds and %0d frames past the end, over %0d register writes",
               rewind_count, drop_count, write_count);
      if (err_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: files.f
rtl/tlfo_pkg.sv
rtl/tlfo_lane.sv
rtl/track_length_linear_fade_out_core.sv
tb/tb_top.sv
